// File: design/rgbg_pkg.sv
// Shared types and constants for the RGB table grading block.
// No dependencies; every other file of the block but rgbg_ram imports this package.
package rgbg_pkg;

	localparam int PIX_W     = 8;
	localparam int CH_COUNT  = 3;
	localparam int SAT_W     = 12;
	localparam int CFG_IDX_W = 1;
	localparam int LN_W      = 16;  // 256 * 255 fits
	localparam int DIFF_W    = 17;  // c*256 - luma, signed
	localparam int PROD_W    = 30;  // DIFF_W x (SAT_W + 1), signed
	localparam int ACC_W     = 31;  // luma*256 + product + half, signed

	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_PIXEL = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		CH_RED   = 2'd0,
		CH_GREEN = 2'd1,
		CH_BLUE  = 2'd2
	} channel_t;

	localparam logic [CFG_IDX_W-1:0] CFG_GRADING_ENABLED = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SATURATION      = 1'b1;

	localparam logic [SAT_W-1:0] SAT_UNITY = 12'd256;

	localparam logic [LN_W-1:0] LUMA_R = 16'd77;
	localparam logic [LN_W-1:0] LUMA_G = 16'd150;
	localparam logic [LN_W-1:0] LUMA_B = 16'd29;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = 31'sd32768;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} pipe_ctl_t;

	typedef struct packed {
		logic             grading_enabled;
		logic [SAT_W-1:0] saturation;
	} grade_cfg_t;

endpackage

// File: design/rgbg_item_if.sv
// Input channel of the grading block: table load or RGBA pixel word.
// Depends on rgbg_pkg.
interface rgbg_item_if;
	import rgbg_pkg::*;

	logic       valid;
	logic       ready;
	logic       cmd;
	logic [1:0] table_channel;
	pix_t       table_index;
	pix_t       table_value;
	pix_t       red_in;
	pix_t       green_in;
	pix_t       blue_in;
	pix_t       alpha_in;

	modport source (
		output valid, cmd, table_channel, table_index, table_value,
		output red_in, green_in, blue_in, alpha_in,
		input  ready
	);

	modport sink (
		input  valid, cmd, table_channel, table_index, table_value,
		input  red_in, green_in, blue_in, alpha_in,
		output ready
	);
endinterface

// File: design/rgbg_result_if.sv
// Output channel of the grading block: one graded RGBA word per pixel.
// Depends on rgbg_pkg.
interface rgbg_result_if;
	import rgbg_pkg::*;

	logic valid;
	logic ready;
	pix_t red_out;
	pix_t green_out;
	pix_t blue_out;
	pix_t alpha_out;

	modport source (
		output valid, red_out, green_out, blue_out, alpha_out,
		input  ready
	);

	modport sink (
		input  valid, red_out, green_out, blue_out, alpha_out,
		output ready
	);
endinterface

// File: design/rgb_lut_grade_saturation.sv
// Top level of the RGB table grading block; holds config registers and pipeline control.
// Depends on rgbg_pkg, rgbg_item_if, rgbg_result_if, rgbg_tables and rgbg_grade.
//
// Takes one word per clock: a table load (cmd 0) writes one entry of the red,
// green or blue table and yields nothing; a pixel (cmd 1) yields one graded
// RGBA word after its registered steps (table read, luma, multiply, round
// and clamp). The rate of one word per cycle is set by the three tables, each
// a synchronous RAM with one write and one read port: a load uses a write
// port, a pixel the three read ports, so a pixel right after a load already
// sees the new entry. Words leave in order; ready drops only when the result
// register is full and the result is not taken. The tables are not cleared
// at reset and must be loaded before pixels are sent with grading enabled.
// Write grading_enabled and saturation only while no pixel is in flight.
module rgb_lut_grade_saturation #(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rgbg_item_if.sink                      items,
	rgbg_result_if.source                  results,
	input  logic                           cfg_we,
	input  logic [rgbg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rgbg_pkg::SAT_W-1:0]     cfg_wdata
);
	import rgbg_pkg::*;

	logic             grading_enabled_q;
	logic [SAT_W-1:0] saturation_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic word_fire, pix_fire, load_fire;

	pipe_ctl_t  ctl;
	grade_cfg_t cfg;

	pix_t raw_pix [CH_COUNT];
	pix_t lut_s1 [CH_COUNT];
	pix_t color_out [CH_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grading_enabled_q <= 1'b0;
			saturation_q      <= SAT_UNITY;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRADING_ENABLED: grading_enabled_q <= cfg_wdata[0];
				CFG_SATURATION:      saturation_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg.grading_enabled = grading_enabled_q;
	assign cfg.saturation      = saturation_q;

	// each stage moves when it is empty or the stage after it moves
	always_comb begin
		ctl.en_s4 = !v_s4 || results.ready;
		ctl.en_s3 = !v_s3 || ctl.en_s4;
		ctl.en_s2 = !v_s2 || ctl.en_s3;
		ctl.en_s1 = !v_s1 || ctl.en_s2;
	end

	assign items.ready = ctl.en_s1;
	assign word_fire   = items.valid && items.ready;
	assign pix_fire    = word_fire && (items.cmd == CMD_PIXEL);
	assign load_fire   = word_fire && (items.cmd == CMD_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ctl.en_s1) v_s1 <= pix_fire;
			if (ctl.en_s2) v_s2 <= v_s1;
			if (ctl.en_s3) v_s3 <= v_s2;
			if (ctl.en_s4) v_s4 <= v_s3;
		end
	end

	assign raw_pix[0] = items.red_in;
	assign raw_pix[1] = items.green_in;
	assign raw_pix[2] = items.blue_in;

	rgbg_tables #(
		.ENTRIES(TABLE_ENTRIES)
	) u_tables (
		.clk          (clk),
		.load_fire    (load_fire),
		.table_channel(items.table_channel),
		.table_index  (items.table_index),
		.table_value  (items.table_value),
		.rd_en        (ctl.en_s1),
		.rd_addr      (raw_pix),
		.rd_data      (lut_s1)
	);

	rgbg_grade u_grade (
		.clk      (clk),
		.ctl      (ctl),
		.cfg      (cfg),
		.raw_in   (raw_pix),
		.alpha_in (items.alpha_in),
		.lut_s1   (lut_s1),
		.color_out(color_out),
		.alpha_out(results.alpha_out)
	);

	assign results.valid     = v_s4;
	assign results.red_out   = color_out[0];
	assign results.green_out = color_out[1];
	assign results.blue_out  = color_out[2];
endmodule

// File: design/rgbg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rgbg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: design/rgbg_tables.sv
// Three per-channel lookup tables, each one rgbg_ram; load decode and pixel lookup.
// Depends on rgbg_pkg and rgbg_ram.
module rgbg_tables #(
	parameter int ENTRIES = 256
) (
	input  logic          clk,
	input  logic          load_fire,
	input  logic [1:0]    table_channel,
	input  rgbg_pkg::pix_t table_index,
	input  rgbg_pkg::pix_t table_value,
	input  logic          rd_en,
	input  rgbg_pkg::pix_t rd_addr [rgbg_pkg::CH_COUNT],
	output rgbg_pkg::pix_t rd_data [rgbg_pkg::CH_COUNT]
);
	import rgbg_pkg::*;

	localparam int AW = $clog2(ENTRIES);

	logic [CH_COUNT-1:0] we;

	// a load naming no table (code 3) writes nothing
	always_comb begin
		we = '0;
		if (load_fire) begin
			case (table_channel)
				CH_RED:   we[0] = 1'b1;
				CH_GREEN: we[1] = 1'b1;
				CH_BLUE:  we[2] = 1'b1;
				default:  we = '0;
			endcase
		end
	end

	for (genvar ch = 0; ch < CH_COUNT; ch++) begin : g_table
		rgbg_ram #(
			.WIDTH(PIX_W),
			.DEPTH(ENTRIES)
		) u_ram (
			.clk  (clk),
			.we   (we[ch]),
			.waddr(AW'(table_index)),
			.wdata(table_value),
			.re   (rd_en),
			.raddr(AW'(rd_addr[ch])),
			.rdata(rd_data[ch])
		);
	end
endmodule

// File: design/rgbg_grade.sv
// Grading datapath after the table read: luma, saturation blend, round and clamp.
// Depends on rgbg_pkg; stage enables come from the top-level control.
module rgbg_grade (
	input  logic                clk,
	input  rgbg_pkg::pipe_ctl_t ctl,
	input  rgbg_pkg::grade_cfg_t cfg,
	input  rgbg_pkg::pix_t      raw_in [rgbg_pkg::CH_COUNT],
	input  rgbg_pkg::pix_t      alpha_in,
	input  rgbg_pkg::pix_t      lut_s1 [rgbg_pkg::CH_COUNT],
	output rgbg_pkg::pix_t      color_out [rgbg_pkg::CH_COUNT],
	output rgbg_pkg::pix_t      alpha_out
);
	import rgbg_pkg::*;

	pix_t raw_s1 [CH_COUNT];
	pix_t alpha_s1;

	pix_t            c_s2 [CH_COUNT];
	logic [LN_W-1:0] ln_s2;
	pix_t            alpha_s2;

	logic signed [PROD_W-1:0] prod_s3 [CH_COUNT];
	pix_t                     c_s3 [CH_COUNT];
	logic [LN_W-1:0]          ln_s3;
	pix_t                     alpha_s3;

	pix_t color_s4 [CH_COUNT];
	pix_t alpha_s4;

	pix_t                     c_sel [CH_COUNT];
	logic [LN_W-1:0]          ln_sum;
	logic signed [DIFF_W-1:0] diff [CH_COUNT];
	logic signed [SAT_W:0]    sat_sgn;
	logic signed [ACC_W-1:0]  acc [CH_COUNT];
	pix_t                     blend [CH_COUNT];
	logic                     bypass;

	// s1: raw pixel alongside the table read data
	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			for (int ch = 0; ch < CH_COUNT; ch++) begin
				raw_s1[ch] <= raw_in[ch];
			end
			alpha_s1 <= alpha_in;
		end
	end

	always_comb begin
		for (int ch = 0; ch < CH_COUNT; ch++) begin
			c_sel[ch] = cfg.grading_enabled ? lut_s1[ch] : raw_s1[ch];
		end
		ln_sum = LUMA_R * LN_W'(c_sel[0]) + LUMA_G * LN_W'(c_sel[1])
			+ LUMA_B * LN_W'(c_sel[2]);
	end

	// s2: mapped colors and luma numerator
	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			c_s2     <= c_sel;
			ln_s2    <= ln_sum;
			alpha_s2 <= alpha_s1;
		end
	end

	always_comb begin
		sat_sgn = $signed({1'b0, cfg.saturation});
		for (int ch = 0; ch < CH_COUNT; ch++) begin
			diff[ch] = $signed({1'b0, c_s2[ch], 8'd0}) - $signed({1'b0, ln_s2});
		end
	end

	// s3: one multiplier per channel lane
	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			for (int ch = 0; ch < CH_COUNT; ch++) begin
				prod_s3[ch] <= diff[ch] * sat_sgn;
			end
			c_s3     <= c_s2;
			ln_s3    <= ln_s2;
			alpha_s3 <= alpha_s2;
		end
	end

	always_comb begin
		bypass = !cfg.grading_enabled || (cfg.saturation == SAT_UNITY);
		for (int ch = 0; ch < CH_COUNT; ch++) begin
			acc[ch] = $signed({7'd0, ln_s3, 8'd0}) + {prod_s3[ch][PROD_W-1], prod_s3[ch]}
				+ ROUND_HALF;
			if (acc[ch][ACC_W-1]) begin
				blend[ch] = '0;
			end else if (|acc[ch][ACC_W-2:24]) begin
				blend[ch] = '1;
			end else begin
				blend[ch] = acc[ch][23:16];
			end
		end
	end

	// s4: result register
	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			for (int ch = 0; ch < CH_COUNT; ch++) begin
				color_s4[ch] <= bypass ? c_s3[ch] : blend[ch];
			end
			alpha_s4 <= alpha_s3;
		end
	end

	assign color_out = color_s4;
	assign alpha_out = alpha_s4;
endmodule

// File: design/rgbg_checker.sv
// Port-level assertions for the RGB table grading block, bound to its top level.
// Depends on rgbg_pkg and the top level rgb_lut_grade_saturation.
module rgbg_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           item_valid,
	input logic           item_ready,
	input logic           item_cmd,
	input logic           result_valid,
	input logic           result_ready,
	input rgbg_pkg::pix_t red_out,
	input rgbg_pkg::pix_t green_out,
	input rgbg_pkg::pix_t blue_out,
	input rgbg_pkg::pix_t alpha_out
);
	import rgbg_pkg::*;

	logic [2:0] pend_q;
	logic       pix_fire, res_fire;

	assign pix_fire = item_valid && item_ready && (item_cmd == CMD_PIXEL);
	assign res_fire = result_valid && result_ready;

	// pixel words taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (pix_fire && !res_fire) begin
			pend_q <= pend_q + 3'd1;
		end else if (res_fire && !pix_fire) begin
			pend_q <= pend_q - 3'd1;
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid
			&& $stable({red_out, green_out, blue_out, alpha_out}))
		else $error("stalled result word changed or dropped");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != 3'd0)
		else $error("result word without a pixel word behind it");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("more pixel words in flight than pipeline stages");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("input stalled while result register is empty");
endmodule

bind rgb_lut_grade_saturation rgbg_checker u_rgbg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (items.valid),
	.item_ready  (items.ready),
	.item_cmd    (items.cmd),
	.result_valid(results.valid),
	.result_ready(results.ready),
	.red_out     (results.red_out),
	.green_out   (results.green_out),
	.blue_out    (results.blue_out),
	.alpha_out   (results.alpha_out)
);

// File: tb/rgb_lut_grade_saturation_tb.sv
// Self-checking bench for rgb_lut_grade_saturation: table loads and RGBA pixels in,
// graded pixels out, checked against an in-bench table/luma/saturation predictor.
// Depends on rgbg_pkg, rgbg_item_if, rgbg_result_if and the block itself.
module rgb_lut_grade_saturation_tb;
	import rgbg_pkg::*;

	localparam logic [1:0] CH_NONE = 2'd3;  // fourth table code, loads are dropped
	localparam int TAIL_CYCLES = 10;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_WORDS = 120;

	typedef struct packed {
		cmd_t       cmd;
		logic [1:0] chan;
		pix_t       index;
		pix_t       value;
		pix_t       red;
		pix_t       green;
		pix_t       blue;
		pix_t       alpha;
	} word_t;

	typedef struct packed {
		pix_t red;
		pix_t green;
		pix_t blue;
		pix_t alpha;
	} graded_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SAT_W-1:0] cfg_wdata;

	rgbg_item_if item_bus();
	rgbg_result_if result_bus();

	rgb_lut_grade_saturation uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (item_bus),
		.results  (result_bus),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// predictor state
	pix_t color_table [CH_COUNT][256];
	logic grade_on;
	logic [SAT_W-1:0] sat_level;

	word_t pending_words[$];
	graded_t expected_pixels[$];
	word_t live_word;
	int words_queued;
	int words_taken;
	int pixels_checked;
	int mismatch_count;
	int send_gap;
	int hold_cycles;
	int quiet_cycles;
	bit idling_on;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic pix_t blend_level(pix_t c, int unsigned luma_num, logic [SAT_W-1:0] s);
		longint acc;
		acc = longint'(luma_num) * 256 + (longint'(c) * 256 - longint'(luma_num)) * longint'(s)
			+ 32768;
		if (acc < 0)
			return '0;
		if ((acc >> 16) > 255)
			return 8'd255;
		return acc[23:16];
	endfunction

	function automatic graded_t grade_pixel(word_t w);
		graded_t g;
		int unsigned luma_num;
		g = '{w.red, w.green, w.blue, w.alpha};
		if (grade_on) begin
			g.red   = color_table[CH_RED][w.red];
			g.green = color_table[CH_GREEN][w.green];
			g.blue  = color_table[CH_BLUE][w.blue];
			if (sat_level != SAT_UNITY) begin
				luma_num = LUMA_R * g.red + LUMA_G * g.green + LUMA_B * g.blue;
				g.red   = blend_level(g.red, luma_num, sat_level);
				g.green = blend_level(g.green, luma_num, sat_level);
				g.blue  = blend_level(g.blue, luma_num, sat_level);
			end
		end
		return g;
	endfunction

	task automatic take_word(word_t w);
		if (w.cmd == CMD_LOAD) begin
			if (w.chan != CH_NONE)
				color_table[w.chan][w.index] = w.value;
		end else begin
			expected_pixels.push_back(grade_pixel(w));
		end
		words_taken++;
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_result();
		graded_t got, want;
		got = '{result_bus.red_out, result_bus.green_out, result_bus.blue_out,
			result_bus.alpha_out};
		if (expected_pixels.size() == 0) begin
			report_mismatch("unrequested word (red shown)", got.red, -1);
			return;
		end
		want = expected_pixels.pop_front();
		pixels_checked++;
		if (got.red !== want.red)
			report_mismatch("red_out", got.red, want.red);
		if (got.green !== want.green)
			report_mismatch("green_out", got.green, want.green);
		if (got.blue !== want.blue)
			report_mismatch("blue_out", got.blue, want.blue);
		if (got.alpha !== want.alpha)
			report_mismatch("alpha_out", got.alpha, want.alpha);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_bus.valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (item_bus.valid && item_bus.ready)
				take_word(live_word);
			if (!item_bus.valid || item_bus.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					item_bus.valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					live_word = pending_words.pop_front();
					item_bus.cmd           <= live_word.cmd;
					item_bus.table_channel <= live_word.chan;
					item_bus.table_index   <= live_word.index;
					item_bus.table_value   <= live_word.value;
					item_bus.red_in        <= live_word.red;
					item_bus.green_in      <= live_word.green;
					item_bus.blue_in       <= live_word.blue;
					item_bus.alpha_in      <= live_word.alpha;
					item_bus.valid         <= 1'b1;
					if (idling_on && $urandom_range(0, 19) == 0)
						send_gap = $urandom_range(1, 10);
				end else begin
					item_bus.valid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
			hold_cycles = 0;
		end else begin
			if (result_bus.valid && result_bus.ready)
				check_result();
			if (hold_cycles > 0) begin
				hold_cycles--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
				if (idling_on && $urandom_range(0, 15) == 0)
					hold_cycles = $urandom_range(1, 10);
			end
		end
	end

	// watchdog: cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[%0t] no traffic for %0d cycles", $realtime, STALL_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	function automatic pix_t rand_level();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return pix_t'($urandom);
		endcase
	endfunction

	function automatic word_t pixel_word(pix_t r, pix_t g, pix_t b, pix_t a);
		word_t w;
		w.cmd   = CMD_PIXEL;
		w.chan  = 2'($urandom);
		w.index = pix_t'($urandom);
		w.value = pix_t'($urandom);
		w.red   = r;
		w.green = g;
		w.blue  = b;
		w.alpha = a;
		return w;
	endfunction

	function automatic word_t load_word(logic [1:0] ch, pix_t idx, pix_t val);
		word_t w;
		w = pixel_word(pix_t'($urandom), pix_t'($urandom), pix_t'($urandom), pix_t'($urandom));
		w.cmd   = CMD_LOAD;
		w.chan  = ch;
		w.index = idx;
		w.value = val;
		return w;
	endfunction

	task automatic queue_word(word_t w);
		pending_words.push_back(w);
		words_queued++;
	endtask

	task automatic queue_random(int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 4) == 0)
				queue_word(load_word(2'($urandom_range(0, 3)), pix_t'($urandom),
					pix_t'($urandom)));
			else
				queue_word(pixel_word(rand_level(), rand_level(), rand_level(),
					pix_t'($urandom)));
		end
	endtask

	task automatic wait_drained();
		while (words_taken != words_queued || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SAT_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_GRADING_ENABLED)
			grade_on = val[0];
		else
			sat_level = val;
	endtask

	task automatic set_grading(logic on, logic [SAT_W-1:0] sat);
		write_reg(CFG_GRADING_ENABLED, {{(SAT_W-1){1'b0}}, on});
		write_reg(CFG_SATURATION, sat);
	endtask

	initial begin
		logic [SAT_W-1:0] sat_pick;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_GRADING_ENABLED;
		cfg_wdata = '0;
		item_bus.valid = 1'b0;
		item_bus.cmd = CMD_LOAD;
		item_bus.table_channel = CH_RED;
		item_bus.table_index = '0;
		item_bus.table_value = '0;
		item_bus.red_in = '0;
		item_bus.green_in = '0;
		item_bus.blue_in = '0;
		item_bus.alpha_in = '0;
		result_bus.ready = 1'b0;
		grade_on = 1'b0;
		sat_level = SAT_UNITY;
		words_queued = 0;
		words_taken = 0;
		pixels_checked = 0;
		mismatch_count = 0;
		quiet_cycles = 0;
		idling_on = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// grading off at reset: pixels pass, loads still land in the tables
		queue_word(pixel_word(8'd0, 8'd0, 8'd0, 8'd0));
		queue_word(pixel_word(8'd255, 8'd255, 8'd255, 8'd255));
		queue_word(pixel_word(8'd17, 8'd200, 8'd93, 8'd128));
		for (int ch = 0; ch < CH_COUNT; ch++)
			for (int i = 0; i < 256; i++)
				queue_word(load_word(2'(ch), pix_t'(i),
					(i == 0) ? 8'd0 : (i == 255) ? 8'd255 : pix_t'($urandom)));
		queue_word(load_word(CH_NONE, 8'd255, 8'd255));
		wait_drained();

		set_grading(1'b1, SAT_UNITY);
		queue_word(pixel_word(8'd0, 8'd0, 8'd0, 8'd0));
		queue_word(pixel_word(8'd255, 8'd255, 8'd255, 8'd255));
		queue_word(pixel_word(8'd255, 8'd0, 8'd0, 8'd77));
		// a pixel queued right behind the load of the entry it reads
		queue_word(load_word(CH_RED, 8'd200, 8'd3));
		queue_word(pixel_word(8'd200, 8'd128, 8'd64, 8'd1));
		wait_drained();

		set_grading(1'b1, 12'd0);
		queue_word(pixel_word(8'd255, 8'd0, 8'd0, 8'd9));
		queue_word(pixel_word(8'd12, 8'd200, 8'd90, 8'd250));
		wait_drained();

		// max saturation: clamps at both ends
		set_grading(1'b1, 12'd4095);
		queue_word(pixel_word(8'd255, 8'd0, 8'd0, 8'd0));
		queue_word(pixel_word(8'd0, 8'd255, 8'd0, 8'd255));
		queue_word(pixel_word(8'd0, 8'd0, 8'd255, 8'd42));
		queue_word(pixel_word(8'd255, 8'd255, 8'd0, 8'd200));
		queue_word(pixel_word(8'd128, 8'd128, 8'd128, 8'd128));
		wait_drained();

		set_grading(1'b1, 12'd255);
		queue_word(pixel_word(8'd90, 8'd30, 8'd220, 8'd5));
		wait_drained();
		set_grading(1'b1, 12'd257);
		queue_word(pixel_word(8'd90, 8'd30, 8'd220, 8'd5));
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: sat_pick = SAT_UNITY;
				1: sat_pick = 12'd4095;
				2: sat_pick = 12'd0;
				5: sat_pick = 12'd512;
				default: sat_pick = SAT_W'($urandom_range(0, 4095));
			endcase
			set_grading(ph != 3, sat_pick);
			idling_on = (ph != 2 && ph != 7);
			if (ph == 4) begin
				// sender holds off until everything in flight has come back
				queue_random(PHASE_WORDS / 2);
				wait_drained();
				queue_random(PHASE_WORDS / 2);
			end else begin
				queue_random(PHASE_WORDS);
			end
			wait_drained();
		end

		if (expected_pixels.size() != 0)
			report_mismatch("pixels never returned", 0, expected_pixels.size());
		$display("%0d words sent, %0d graded pixels checked, %0d mismatches",
			words_taken, pixels_checked, mismatch_count);
		$display("covered: full table load, grading off/on, saturation 0, unity, 4095 and random");
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
